/* design/path_command_absolutizer_assert.svh */
// Assertion macros shared by the path command absolutizer modules.
`ifndef PATH_COMMAND_ABSOLUTIZER_ASSERT_SVH
`define PATH_COMMAND_ABSOLUTIZER_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define PCA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/pca_pkg.sv */
// Package with the command codes, segment kinds and channel payload types.
`default_nettype none

package pca_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH         = 32;

   localparam logic [2:0] MODE_MOVE    = 3'd0;
   localparam logic [2:0] MODE_LINE    = 3'd1;
   localparam logic [2:0] MODE_HORIZ   = 3'd2;
   localparam logic [2:0] MODE_VERT    = 3'd3;
   localparam logic [2:0] MODE_CUBIC   = 3'd4;
   localparam logic [2:0] MODE_SMOOTH  = 3'd5;
   localparam logic [2:0] MODE_CLOSE   = 3'd6;
   localparam logic [2:0] MODE_INVALID = 3'd7;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_CUBIC = 2'd2;
   localparam logic [1:0] KIND_CLOSE = 2'd3;

   typedef struct packed {
      logic [2:0]                      mode;
      logic                            is_relative;
      logic                            letter_present;
      logic signed [FIELD_WIDTH-1:0]   ctrl1_x;
      logic signed [FIELD_WIDTH-1:0]   ctrl1_y;
      logic signed [FIELD_WIDTH-1:0]   ctrl2_x;
      logic signed [FIELD_WIDTH-1:0]   ctrl2_y;
      logic signed [FIELD_WIDTH-1:0]   end_x;
      logic signed [FIELD_WIDTH-1:0]   end_y;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                      segment_kind;
      logic signed [FIELD_WIDTH-1:0]   from_x;
      logic signed [FIELD_WIDTH-1:0]   from_y;
      logic signed [FIELD_WIDTH-1:0]   c1_x;
      logic signed [FIELD_WIDTH-1:0]   c1_y;
      logic signed [FIELD_WIDTH-1:0]   c2_x;
      logic signed [FIELD_WIDTH-1:0]   c2_y;
      logic signed [FIELD_WIDTH-1:0]   to_x;
      logic signed [FIELD_WIDTH-1:0]   to_y;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* design/pca_channels.sv */
// Valid/ready channel interfaces for path command requests and segment results.
`default_nettype none

interface pca_req_if
   import pca_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pca_rsp_if
   import pca_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/path_command_absolutizer.sv */
// Top level of the path command absolutizer: request and result registers.
`default_nettype none
`include "path_command_absolutizer_assert.svh"

// Converts one path command request (move, line, horizontal, vertical, cubic,
// smooth cubic or close, absolute or relative, with or without a letter) into
// one absolute segment with start, two controls and end in signed Q16.16.
// Requests that repeat a missing command or carry mode 7 produce no result.
// A request is registered, then decoded and resolved against the current point
// combinationally, and the segment lands in a result register; one request per
// cycle is taken while the result side keeps up. The result is valid right after
// the clock edge on which its request leaves the input register.
// The current point, subpath start, last control, sticky command and curve
// flag update in the cycle a request that is not dropped leaves the input
// register, so the next request sees them without delay.

module path_command_absolutizer
   import pca_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   pca_req_if.sink   req_chan,
   pca_rsp_if.source rsp_chan
);

   req_payload_type in_ff;
   logic            in_valid_ff, in_valid_in;
   rsp_payload_type out_ff;
   logic            out_valid_ff, out_valid_in;

   rsp_payload_type result;
   logic            drop;
   logic            advance;
   logic            req_fire;

   pca_core #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .item   (in_ff),
      .fire   (advance),
      .result (result),
      .drop   (drop)
   );

   // A dropped request leaves without needing room in the result register.
   assign advance        = in_valid_ff && (drop || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = (advance && !drop) || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_chan.payload;
      end
      if (advance && !drop) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   `PCA_ASSERT_NOW(a_free_output_advances, in_valid_ff && !out_valid_ff, advance,
      "request held although the result register is empty")
   `PCA_ASSERT_NEXT(a_result_lands, advance && !drop, out_valid_ff,
      "processed request left no result")
   `PCA_ASSERT_NEXT(a_request_kept, in_valid_ff && !advance, in_valid_ff,
      "stalled request lost from the input register")

endmodule

`default_nettype wire

/* design/pca_core.sv */
// Command decode, saturating coordinate math and path state registers.
`default_nettype none
`include "path_command_absolutizer_assert.svh"

module pca_core
   import pca_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type item,
   input  wire logic            fire,
   output rsp_payload_type      result,
   output logic                 drop
);

   localparam int CW = COORD_WIDTH;
   localparam int OW = (CW > FIELD_WIDTH) ? CW : FIELD_WIDTH;
   localparam int XW = OW + 1;

   localparam logic signed [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [XW-1:0] X_MAX  = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [XW-1:0] X_MIN  = ~X_MAX;
   localparam logic signed [CW-1:0] C_ZERO = '0;

   typedef logic signed [CW-1:0] coord_type;

   function automatic coord_type clamp_in(input logic signed [FIELD_WIDTH-1:0] v);
      logic signed [XW-1:0] e;
      e = XW'(v);
      if (e > X_MAX) begin
         return C_MAX;
      end else if (e < X_MIN) begin
         return C_MIN;
      end
      return e[CW-1:0];
   endfunction

   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [CW:0] s;
      s = (CW+1)'(a) + (CW+1)'(b);
      if (s[CW] != s[CW-1]) begin
         return s[CW] ? C_MIN : C_MAX;
      end
      return s[CW-1:0];
   endfunction

   function automatic coord_type sat_sub(input coord_type a, input coord_type b);
      logic signed [CW:0] s;
      s = (CW+1)'(a) - (CW+1)'(b);
      if (s[CW] != s[CW-1]) begin
         return s[CW] ? C_MIN : C_MAX;
      end
      return s[CW-1:0];
   endfunction

   function automatic logic signed [FIELD_WIDTH-1:0] out_field(input coord_type v);
      logic signed [OW-1:0] t;
      t = OW'(v);
      return t[FIELD_WIDTH-1:0];
   endfunction

   coord_type  cur_x_ff, cur_y_ff, start_x_ff, start_y_ff, last_x_ff, last_y_ff;
   logic [3:0] sticky_ff;
   logic       sticky_valid_ff;
   logic       prev_curve_ff;

   logic [3:0] cmd;
   logic [2:0] mode;
   logic       rel;
   coord_type  off_x, off_y;
   coord_type  from_x, from_y, a_x, a_y, b_x, b_y, t_x, t_y;
   coord_type  move_x, move_y, c1_x, c1_y, c2_x, c2_y;
   coord_type  dbl_x, dbl_y;
   logic [1:0] kind;
   logic       curve;

   assign cmd  = item.letter_present ? {item.is_relative, item.mode} : sticky_ff;
   assign mode = cmd[2:0];
   assign rel  = cmd[3];
   assign drop = (!item.letter_present && !sticky_valid_ff) || (mode == MODE_INVALID);

   assign off_x  = rel ? cur_x_ff : C_ZERO;
   assign off_y  = rel ? cur_y_ff : C_ZERO;
   assign move_x = sat_add(clamp_in(item.end_x), off_x);
   assign move_y = sat_add(clamp_in(item.end_y), off_y);
   assign c1_x   = sat_add(clamp_in(item.ctrl1_x), off_x);
   assign c1_y   = sat_add(clamp_in(item.ctrl1_y), off_y);
   assign c2_x   = sat_add(clamp_in(item.ctrl2_x), off_x);
   assign c2_y   = sat_add(clamp_in(item.ctrl2_y), off_y);
   // Mirror step: 2*current saturates before the last control is taken off.
   assign dbl_x  = sat_add(cur_x_ff, cur_x_ff);
   assign dbl_y  = sat_add(cur_y_ff, cur_y_ff);

   always_comb begin
      from_x = cur_x_ff;
      from_y = cur_y_ff;
      a_x    = cur_x_ff;
      a_y    = cur_y_ff;
      b_x    = move_x;
      b_y    = move_y;
      t_x    = move_x;
      t_y    = move_y;
      kind   = KIND_LINE;
      curve  = 1'b0;
      unique case (mode)
         MODE_MOVE: begin
            from_x = move_x;
            from_y = move_y;
            a_x    = move_x;
            a_y    = move_y;
            kind   = KIND_START;
         end
         MODE_LINE: begin
            kind = KIND_LINE;
         end
         MODE_HORIZ: begin
            t_y  = cur_y_ff;
            b_y  = cur_y_ff;
            kind = KIND_LINE;
         end
         MODE_VERT: begin
            t_x  = cur_x_ff;
            b_x  = cur_x_ff;
            kind = KIND_LINE;
         end
         MODE_CUBIC: begin
            a_x   = c1_x;
            a_y   = c1_y;
            b_x   = c2_x;
            b_y   = c2_y;
            kind  = KIND_CUBIC;
            curve = 1'b1;
         end
         MODE_SMOOTH: begin
            if (prev_curve_ff) begin
               a_x = sat_sub(dbl_x, last_x_ff);
               a_y = sat_sub(dbl_y, last_y_ff);
            end
            b_x   = c2_x;
            b_y   = c2_y;
            kind  = KIND_CUBIC;
            curve = 1'b1;
         end
         MODE_CLOSE: begin
            t_x  = start_x_ff;
            t_y  = start_y_ff;
            b_x  = start_x_ff;
            b_y  = start_y_ff;
            kind = KIND_CLOSE;
         end
         default: begin
            kind = KIND_LINE;
         end
      endcase
   end

   always_comb begin
      result.segment_kind = kind;
      result.from_x       = out_field(from_x);
      result.from_y       = out_field(from_y);
      result.c1_x         = out_field(a_x);
      result.c1_y         = out_field(a_y);
      result.c2_x         = out_field(b_x);
      result.c2_y         = out_field(b_y);
      result.to_x         = out_field(t_x);
      result.to_y         = out_field(t_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff        <= '0;
         cur_y_ff        <= '0;
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         sticky_ff       <= '0;
         sticky_valid_ff <= 1'b0;
         prev_curve_ff   <= 1'b0;
      end else if (fire && !drop) begin
         cur_x_ff        <= t_x;
         cur_y_ff        <= t_y;
         last_x_ff       <= b_x;
         last_y_ff       <= b_y;
         prev_curve_ff   <= curve;
         sticky_valid_ff <= 1'b1;
         if (mode == MODE_MOVE) begin
            start_x_ff <= t_x;
            start_y_ff <= t_y;
            // Coordinates after a move repeat as lines of the same relativity.
            sticky_ff  <= {rel, MODE_LINE};
         end else begin
            sticky_ff  <= cmd;
         end
      end
   end

   `PCA_ASSERT_NOW(a_sticky_not_move, sticky_valid_ff, sticky_ff[2:0] != MODE_MOVE,
      "sticky command holds a move")
   `PCA_ASSERT_NOW(a_curve_needs_sticky, prev_curve_ff, sticky_valid_ff,
      "curve flag set before any command")
   `PCA_ASSERT_NEXT(a_step_sets_sticky, fire && !drop, sticky_valid_ff,
      "sticky command not valid after a processed request")

endmodule

`default_nettype wire
